FILE: sv/tsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  // Scan frame geometry
  localparam int NUM_FRAMES  = 5;
  localparam int FRAME_BITS  = 15;
  localparam int FRAME_IDX_W = 3;
  localparam int BIT_IDX_W   = 4;

  // Field and register widths
  localparam int COORD_W    = 12;
  localparam int HALF_W     = 8;
  localparam int IVAL_W     = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  // Pressure datapath: diff * 400 * x stays below 2^33
  localparam int PROD_W     = 33;
  localparam int STEP_W     = 6;
  localparam int FRAC_BITS  = 12;
  localparam logic [PROD_W:0]      ROUND_BIAS = (PROD_W + 1)'(2047);
  localparam logic [COORD_W-1:0]   PRESS_MAX  = '1;

  // Register reset values
  localparam logic [HALF_W-1:0] HALF_RESET = 8'd4;
  localparam logic [IVAL_W-1:0] IVAL_RESET = 20'd10000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 1'b1;

  // Request to the pressure unit
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] diff;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z1;
  } press_req_t;

  // Answer from the pressure unit
  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] pressure;
  } press_rsp_t;

  // Fixed command word sent in each frame, MSB first
  function automatic logic [FRAME_BITS-1:0] cmd_word(input logic [FRAME_IDX_W-1:0] frame);
    logic [FRAME_BITS-1:0] w;
    case (frame)
      3'd0:    w = 15'h6980;
      3'd1:    w = 15'h6800;
      3'd2:    w = 15'h4980;
      3'd3:    w = 15'h4800;
      default: w = 15'h0000;
    endcase
    return w;
  endfunction

  // 12-bit sample straddling two response words: low six bits of the first,
  // bits 15..10 of the second (bit 15 is never set in a 15-bit word)
  function automatic logic [COORD_W-1:0] conv12(input logic [FRAME_BITS-1:0] a,
                                                input logic [FRAME_BITS-1:0] b);
    return {a[5:0], 1'b0, b[14:10]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/tsc_tick_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsc_tick_if;
  logic valid;
  logic ready;
  logic miso;
  logic pen_n;

  modport source (output valid, output miso, output pen_n, input ready);
  modport sink   (input valid, input miso, input pen_n, output ready);
endinterface

`default_nettype wire

FILE: sv/tsc_status_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsc_status_if import tsc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               sclk;
  logic               mosi;
  logic               cs_n;
  logic               touching;
  logic               report_valid;
  logic [COORD_W-1:0] x_pos;
  logic [COORD_W-1:0] y_pos;
  logic [COORD_W-1:0] pressure;

  modport source (output valid, output sclk, output mosi, output cs_n, output touching,
                  output report_valid, output x_pos, output y_pos, output pressure,
                  input ready);
  modport sink   (input valid, input sclk, input mosi, input cs_n, input touching,
                  input report_valid, input x_pos, input y_pos, input pressure,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/tsc_press.sv
`timescale 1ns / 1ps
`default_nettype none

// Pressure = ((diff * 400 * x) / z1 + 2047) >> 12, saturated.
// Shift-add multiply over the bits of x, then restoring divide one
// quotient bit per cycle, then a rounding step.
module tsc_press import tsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  press_req_t req,
  output press_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_ROUND} state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   mcand;
  logic [COORD_W-1:0]  mplier;
  logic [COORD_W-1:0]  divisor;
  logic [COORD_W-1:0]  rem;
  logic                done;
  logic [COORD_W-1:0]  pressure;

  logic [PROD_W-1:0]   scaled;
  logic [PROD_W-1:0]   prod_add;
  logic [COORD_W:0]    trial;
  logic [COORD_W:0]    trial_diff;
  logic                fits;
  logic [PROD_W:0]     rounded;
  logic [COORD_W-1:0]  press_sat;

  // diff * 400 as (diff << 8) + (diff << 7) + (diff << 4)
  assign scaled = (PROD_W'(req.diff) << 8) + (PROD_W'(req.diff) << 7)
                + (PROD_W'(req.diff) << 4);

  // One partial product per cycle
  assign prod_add = acc + (mplier[0] ? mcand : '0);

  // Restoring divide step
  assign trial      = {rem, acc[PROD_W-1]};
  assign fits       = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};

  // Round and saturate the quotient
  assign rounded   = {1'b0, acc} + ROUND_BIAS;
  assign press_sat = (|rounded[PROD_W:FRAC_BITS+COORD_W]) ? PRESS_MAX
                   : rounded[FRAC_BITS+COORD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            mcand   <= scaled;
            mplier  <= req.x;
            divisor <= req.z1;
            acc     <= '0;
            rem     <= '0;
            step    <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          acc    <= prod_add;
          mcand  <= {mcand[PROD_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[COORD_W-1:1]};
          if (step == STEP_W'(COORD_W - 1)) begin
            step  <= '0;
            state <= S_DIV;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIV: begin
          rem <= fits ? trial_diff[COORD_W-1:0] : trial[COORD_W-1:0];
          acc <= {acc[PROD_W-2:0], fits};
          if (step == STEP_W'(PROD_W - 1)) begin
            step  <= '0;
            state <= S_ROUND;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ROUND: begin
          pressure <= press_sat;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done     = done;
  assign rsp.pressure = pressure;

endmodule

`default_nettype wire

FILE: sv/touchscreen_adc_scan_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Touchscreen ADC scan sequencer.
// tick: one item per microsecond tick, carrying the sampled miso and pen_n pins.
// status: one item back for every tick, giving the serial pin levels (sclk, mosi,
//   cs_n), the touching flag and, on the tick that ends a scan with nonzero x and
//   z1, a report with x_pos, y_pos and pressure (zero when no report).
// Configuration: cfg_wr_en/cfg_index/cfg_data write the half period (index 0)
//   and the sample interval (index 1); no read-back.
// An ordinary tick gives its item in the cycle after acceptance. A tick
//   that ends a scan with a report waits for the pressure unit: 12 shift-add
//   multiply steps and 33 restoring divide steps in the pressure unit, plus
//   rounding and hand-over.
// Throughput: one tick at a time; a new tick is taken once the previous item
//   is done and the status register is free or being emptied that cycle.
// Reset (rst, synchronous): idle phase, internal touch flag low, counters clear, registers
//   back to 4 and 10000, no item pending.
// A stall on status holds the item in the output register and holds off tick.
module touchscreen_adc_scan_sequencer import tsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tsc_tick_if.sink              tick,
  tsc_status_if.source          status,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {PH_IDLE, PH_SETUP, PH_LOW, PH_HIGH, PH_WAIT} phase_t;

  // Configuration
  logic [HALF_W-1:0]      half_period;
  logic [IVAL_W-1:0]      sample_interval;

  // Scan state
  phase_t                 phase, phase_next;
  logic [HALF_W-1:0]      half_counter, half_counter_next;
  logic [BIT_IDX_W-1:0]   bit_index, bit_index_next;
  logic [FRAME_IDX_W-1:0] frame_index, frame_index_next;
  logic [FRAME_BITS-1:0]  shift_in, shift_in_next;
  logic [FRAME_BITS-1:0]  cmd_shift, cmd_shift_next;
  logic [IVAL_W-1:0]      interval_counter, interval_counter_next;
  logic                   touch_active, touch_active_next;
  logic [FRAME_BITS-1:0]  resp_words [NUM_FRAMES-1];
  logic                   busy;

  // Status register
  logic                   res_valid;
  logic                   res_sclk;
  logic                   res_mosi;
  logic                   res_cs_n;
  logic                   res_touching;
  logic                   res_report;
  logic [COORD_W-1:0]     res_x;
  logic [COORD_W-1:0]     res_y;
  logic [COORD_W-1:0]     res_pressure;

  logic                   accept;
  logic                   pen_down;
  logic [HALF_W-1:0]      half_last;
  logic [IVAL_W-1:0]      interval_last;
  logic                   half_done;
  logic                   interval_done;
  logic                   word_we;
  logic                   scan_end;
  logic                   pin_sclk, pin_mosi, pin_cs_n;
  logic [COORD_W-1:0]     x_val, y_val, z1_val, z2_val;
  logic                   report;
  press_req_t             press_req;
  press_rsp_t             press_rsp;

  assign tick.ready = !busy && (!res_valid || status.ready);
  assign accept     = tick.valid && tick.ready;
  assign pen_down   = !tick.pen_n;

  // Zero period or interval counts as one tick
  assign half_last     = (half_period == '0) ? '0 : half_period - 8'd1;
  assign interval_last = (sample_interval == '0) ? '0 : sample_interval - 20'd1;
  assign half_done     = half_counter >= half_last;
  assign interval_done = interval_counter >= interval_last;

  // Next scan state for one tick
  always_comb begin
    phase_next            = phase;
    half_counter_next     = half_counter;
    bit_index_next        = bit_index;
    frame_index_next      = frame_index;
    shift_in_next         = shift_in;
    cmd_shift_next        = cmd_shift;
    interval_counter_next = interval_counter;
    touch_active_next     = touch_active;
    word_we               = 1'b0;
    scan_end              = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (pen_down) begin
          touch_active_next = 1'b1;
          phase_next        = PH_SETUP;
          half_counter_next = '0;
        end
      end
      PH_SETUP: begin
        if (half_done) begin
          half_counter_next = '0;
          phase_next        = PH_LOW;
          bit_index_next    = '0;
          frame_index_next  = '0;
          shift_in_next     = '0;
          cmd_shift_next    = cmd_word('0);
        end else begin
          half_counter_next = half_counter + 8'd1;
        end
      end
      PH_LOW: begin
        if (half_done) begin
          half_counter_next = '0;
          phase_next        = PH_HIGH;
          shift_in_next     = {shift_in[FRAME_BITS-2:0], tick.miso};
        end else begin
          half_counter_next = half_counter + 8'd1;
        end
      end
      PH_HIGH: begin
        if (half_done) begin
          half_counter_next = '0;
          if (bit_index != BIT_IDX_W'(FRAME_BITS - 1)) begin
            bit_index_next = bit_index + 4'd1;
            phase_next     = PH_LOW;
            cmd_shift_next = {cmd_shift[FRAME_BITS-2:0], 1'b0};
          end else begin
            word_we        = 1'b1;
            shift_in_next  = '0;
            bit_index_next = '0;
            if (frame_index != FRAME_IDX_W'(NUM_FRAMES - 1)) begin
              frame_index_next = frame_index + 3'd1;
              phase_next       = PH_LOW;
              cmd_shift_next   = cmd_word(frame_index + 3'd1);
            end else begin
              frame_index_next = '0;
              scan_end         = 1'b1;
              if (pen_down) begin
                phase_next            = PH_WAIT;
                interval_counter_next = '0;
              end else begin
                phase_next        = PH_IDLE;
                touch_active_next = 1'b0;
              end
            end
          end
        end else begin
          half_counter_next = half_counter + 8'd1;
        end
      end
      PH_WAIT: begin
        if (interval_done) begin
          interval_counter_next = '0;
          if (pen_down) begin
            phase_next        = PH_SETUP;
            half_counter_next = '0;
          end else begin
            phase_next        = PH_IDLE;
            touch_active_next = 1'b0;
          end
        end else begin
          interval_counter_next = interval_counter + 20'd1;
        end
      end
      default: begin
        phase_next        = PH_IDLE;
        touch_active_next = 1'b0;
      end
    endcase
  end

  // Pin levels after the tick
  always_comb begin
    case (phase_next)
      PH_SETUP: begin
        pin_sclk = 1'b0;
        pin_mosi = 1'b0;
        pin_cs_n = 1'b0;
      end
      PH_LOW: begin
        pin_sclk = 1'b0;
        pin_mosi = cmd_shift_next[FRAME_BITS-1];
        pin_cs_n = 1'b0;
      end
      PH_HIGH: begin
        pin_sclk = 1'b1;
        pin_mosi = cmd_shift_next[FRAME_BITS-1];
        pin_cs_n = 1'b0;
      end
      default: begin
        pin_sclk = 1'b0;
        pin_mosi = 1'b0;
        pin_cs_n = 1'b1;
      end
    endcase
  end

  // Samples from the response words; the last word is still in shift_in
  assign x_val  = conv12(resp_words[0], resp_words[1]);
  assign z1_val = conv12(resp_words[1], resp_words[2]);
  assign z2_val = conv12(resp_words[2], resp_words[3]);
  assign y_val  = conv12(resp_words[3], shift_in);
  assign report = scan_end && (x_val != '0) && (z1_val != '0);

  assign press_req.start = accept && report;
  assign press_req.diff  = (z2_val > z1_val) ? z2_val - z1_val : '0;
  assign press_req.x     = x_val;
  assign press_req.z1    = z1_val;

  tsc_press u_press (
    .clk (clk),
    .rst (rst),
    .req (press_req),
    .rsp (press_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period     <= HALF_RESET;
      sample_interval <= IVAL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HALF_PERIOD:     half_period     <= cfg_data[HALF_W-1:0];
        REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Response word store, one word per finished frame but the last
  always_ff @(posedge clk) begin
    if (accept && word_we && (frame_index != FRAME_IDX_W'(NUM_FRAMES - 1))) begin
      resp_words[frame_index[1:0]] <= shift_in;
    end
  end

  // Scan state and status register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      half_counter     <= '0;
      bit_index        <= '0;
      frame_index      <= '0;
      shift_in         <= '0;
      interval_counter <= '0;
      touch_active     <= 1'b0;
      busy             <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        half_counter     <= half_counter_next;
        bit_index        <= bit_index_next;
        frame_index      <= frame_index_next;
        shift_in         <= shift_in_next;
        cmd_shift        <= cmd_shift_next;
        interval_counter <= interval_counter_next;
        touch_active     <= touch_active_next;
        res_sclk         <= pin_sclk;
        res_mosi         <= pin_mosi;
        res_cs_n         <= pin_cs_n;
        res_touching     <= touch_active_next;
        res_report       <= report;
        res_x            <= report ? x_val : '0;
        res_y            <= report ? y_val : '0;
        res_pressure     <= '0;
        // a report waits in the pressure unit before it is shown
        busy             <= report;
        res_valid        <= !report;
      end else if (press_rsp.done) begin
        res_pressure <= press_rsp.pressure;
        busy         <= 1'b0;
        res_valid    <= 1'b1;
      end else if (res_valid && status.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign status.valid        = res_valid;
  assign status.sclk         = res_sclk;
  assign status.mosi         = res_mosi;
  assign status.cs_n         = res_cs_n;
  assign status.touching     = res_touching;
  assign status.report_valid = res_report;
  assign status.x_pos        = res_x;
  assign status.y_pos        = res_y;
  assign status.pressure     = res_pressure;

endmodule

`default_nettype wire

FILE: sv/tsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tsc_checker import tsc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               tick_ready,
  input logic               status_valid,
  input logic               status_ready,
  input logic               status_sclk,
  input logic               status_mosi,
  input logic               status_cs_n,
  input logic               status_report_valid,
  input logic [COORD_W-1:0] status_x_pos,
  input logic [COORD_W-1:0] status_y_pos,
  input logic [COORD_W-1:0] status_pressure
);

  // Nothing pending straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !status_valid)
    else $error("status item present after reset");

  // A held status item blocks further ticks
  a_hold_off: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |-> !tick_ready)
    else $error("tick taken while status item stalled");

  // Reports only come with the bus released
  a_report_pins: assert property (@(posedge clk) disable iff (rst)
    status_valid && status_report_valid |-> status_cs_n && !status_sclk && !status_mosi)
    else $error("report while serial bus active");

  // Without a report the value fields are zero
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_report_valid |->
      status_x_pos == '0 && status_y_pos == '0 && status_pressure == '0)
    else $error("report fields set without a report");

  // The serial clock only runs under chip select
  a_sclk_select: assert property (@(posedge clk) disable iff (rst)
    status_valid && status_sclk |-> !status_cs_n)
    else $error("sclk high with chip select released");

endmodule

bind touchscreen_adc_scan_sequencer tsc_checker u_tsc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .tick_ready          (tick.ready),
  .status_valid        (status.valid),
  .status_ready        (status.ready),
  .status_sclk         (status.sclk),
  .status_mosi         (status.mosi),
  .status_cs_n         (status.cs_n),
  .status_report_valid (status.report_valid),
  .status_x_pos        (status.x_pos),
  .status_y_pos        (status.y_pos),
  .status_pressure     (status.pressure)
);

`default_nettype wire

FILE: test/tsc_scan_checker.sv
`timescale 1ns / 1ps

// Watches the tick and status channels, keeps its own copy of the scan
// sequencer state and checks every status item against the expected pin levels
// and report.
module tsc_scan_checker import tsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tsc_tick_if                   tick,
  tsc_status_if                 status,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    results_owed
);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SETTLE,
    SCAN_CLK_LOW,
    SCAN_CLK_HIGH,
    SCAN_HOLDOFF
  } scan_phase_t;

  typedef struct packed {
    logic               sclk;
    logic               mosi;
    logic               cs_n;
    logic               touching;
    logic               report_valid;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [COORD_W-1:0] pressure;
  } pin_status_t;

  localparam int MAX_REPORTS = 10;

  // Pressure scaling: ((z2 - z1) * x * 400 / z1 + 2047) >> 12
  localparam longint unsigned PRESS_SCALE = 400;
  localparam longint unsigned PRESS_ROUND = 2047;
  localparam int              PRESS_SHIFT = 12;
  localparam longint unsigned PRESS_TOP   = 4095;

  // Command words shifted out, one per frame
  localparam logic [FRAME_BITS-1:0] SCAN_CMDS [NUM_FRAMES] =
    '{15'h6980, 15'h6800, 15'h4980, 15'h4800, 15'h0000};

  // Register copies
  logic [HALF_W-1:0]      half_cfg;
  logic [IVAL_W-1:0]      ival_cfg;

  // Sequencer state copy
  scan_phase_t            phase;
  logic [HALF_W-1:0]      half_cnt;
  logic [BIT_IDX_W-1:0]   bit_idx;
  logic [FRAME_IDX_W-1:0] frame_idx;
  logic [FRAME_BITS-1:0]  shift_reg;
  logic [FRAME_BITS-1:0]  words [NUM_FRAMES];
  logic [IVAL_W-1:0]      ival_cnt;
  logic                   touch;

  pin_status_t            expected_q [$];
  int                     status_no;

  // Counts one tick of the current half period; true on its last tick
  function automatic logic half_period_elapsed();
    int span;
    span = (half_cfg == '0) ? 1 : int'(half_cfg);
    if (int'(half_cnt) + 1 >= span) begin
      half_cnt = '0;
      return 1'b1;
    end
    half_cnt = half_cnt + 1'b1;
    return 1'b0;
  endfunction

  // 12-bit sample: low six bits of one word, a zero, then the top five bits of the next
  function automatic logic [COORD_W-1:0] join_sample(input logic [FRAME_BITS-1:0] hi_w,
                                                     input logic [FRAME_BITS-1:0] lo_w);
    return {hi_w[5:0], 6'(lo_w[FRAME_BITS-1:10])};
  endfunction

  // One tick through the sequencer, giving the status it should return
  task automatic advance_scan(input logic miso_bit, input logic pen_n_bit,
                              output pin_status_t res);
    logic [COORD_W-1:0] x, y, z1, z2, diff;
    longint unsigned    scaled, rounded;
    int                 ival;
    res = '0;
    case (phase)
      SCAN_IDLE: begin
        if (!pen_n_bit) begin
          touch    = 1'b1;
          phase    = SCAN_SETTLE;
          half_cnt = '0;
        end
      end
      SCAN_SETTLE: begin
        if (half_period_elapsed()) begin
          phase     = SCAN_CLK_LOW;
          bit_idx   = '0;
          frame_idx = '0;
          shift_reg = '0;
        end
      end
      SCAN_CLK_LOW: begin
        if (half_period_elapsed()) begin
          phase     = SCAN_CLK_HIGH;
          shift_reg = {shift_reg[FRAME_BITS-2:0], miso_bit};
        end
      end
      SCAN_CLK_HIGH: begin
        if (half_period_elapsed()) begin
          if (int'(bit_idx) < FRAME_BITS - 1) begin
            bit_idx = bit_idx + 1'b1;
            phase   = SCAN_CLK_LOW;
          end else begin
            words[frame_idx] = shift_reg;
            shift_reg = '0;
            bit_idx   = '0;
            if (int'(frame_idx) < NUM_FRAMES - 1) begin
              frame_idx = frame_idx + 1'b1;
              phase     = SCAN_CLK_LOW;
            end else begin
              // last clock fall: build samples and maybe report
              x  = join_sample(words[0], words[1]);
              z1 = join_sample(words[1], words[2]);
              z2 = join_sample(words[2], words[3]);
              y  = join_sample(words[3], words[4]);
              frame_idx = '0;
              if (x != '0 && z1 != '0) begin
                diff    = (z2 > z1) ? z2 - z1 : '0;
                scaled  = (longint'(diff) * longint'(x) * PRESS_SCALE) / longint'(z1);
                rounded = (scaled + PRESS_ROUND) >> PRESS_SHIFT;
                res.report_valid = 1'b1;
                res.x_pos        = x;
                res.y_pos        = y;
                res.pressure     = (rounded > PRESS_TOP) ? '1 : rounded[COORD_W-1:0];
              end
              if (!pen_n_bit) begin
                phase    = SCAN_HOLDOFF;
                ival_cnt = '0;
              end else begin
                phase = SCAN_IDLE;
                touch = 1'b0;
              end
            end
          end
        end
      end
      SCAN_HOLDOFF: begin
        ival = (ival_cfg == '0) ? 1 : int'(ival_cfg);
        if (int'(ival_cnt) + 1 >= ival) begin
          ival_cnt = '0;
          if (!pen_n_bit) begin
            phase    = SCAN_SETTLE;
            half_cnt = '0;
          end else begin
            phase = SCAN_IDLE;
            touch = 1'b0;
          end
        end else begin
          ival_cnt = ival_cnt + 1'b1;
        end
      end
      default: begin
        phase = SCAN_IDLE;
        touch = 1'b0;
      end
    endcase

    // pin levels after the tick
    res.touching = touch;
    case (phase)
      SCAN_SETTLE: begin
        res.cs_n = 1'b0;
      end
      SCAN_CLK_LOW, SCAN_CLK_HIGH: begin
        res.sclk = (phase == SCAN_CLK_HIGH);
        res.mosi = SCAN_CMDS[frame_idx][FRAME_BITS - 1 - int'(bit_idx)];
        res.cs_n = 1'b0;
      end
      default: begin
        res.cs_n = 1'b1;
      end
    endcase
  endtask

  // Sample both channels and the register port on each rising edge
  always @(posedge clk) begin : watch
    pin_status_t got, want;
    if (rst) begin
      half_cfg  = HALF_RESET;
      ival_cfg  = IVAL_RESET;
      phase     = SCAN_IDLE;
      half_cnt  = '0;
      bit_idx   = '0;
      frame_idx = '0;
      shift_reg = '0;
      ival_cnt  = '0;
      touch     = 1'b0;
      expected_q.delete();
      status_no      = 0;
      mismatch_count = 0;
      results_owed   = 0;
    end else begin
      // status items first: none can belong to a tick taken on this edge
      if (status.valid && status.ready) begin
        got = '{status.sclk, status.mosi, status.cs_n, status.touching,
                status.report_valid, status.x_pos, status.y_pos, status.pressure};
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("status item %0d arrived with no tick outstanding", status_no);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("status item %0d wrong at %0t", status_no, $realtime);
              $display("  exp sclk %b mosi %b cs_n %b touch %b rep %b x %0d y %0d p %0d",
                       want.sclk, want.mosi, want.cs_n, want.touching,
                       want.report_valid, want.x_pos, want.y_pos, want.pressure);
              $display("  got sclk %b mosi %b cs_n %b touch %b rep %b x %0d y %0d p %0d",
                       got.sclk, got.mosi, got.cs_n, got.touching,
                       got.report_valid, got.x_pos, got.y_pos, got.pressure);
            end
          end
        end
        status_no++;
      end

      if (cfg_wr_en) begin
        if (cfg_index == REG_HALF_PERIOD)
          half_cfg = cfg_data[HALF_W-1:0];
        else if (cfg_index == REG_SAMPLE_INTERVAL)
          ival_cfg = cfg_data[IVAL_W-1:0];
      end

      if (tick.valid && tick.ready) begin
        advance_scan(tick.miso, tick.pen_n, want);
        expected_q.push_back(want);
      end

      results_owed = expected_q.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Drives pen and miso ticks through whole scans with chosen response words,
// stalls the status side, and leaves the checking to tsc_scan_checker.
module testbench;
  import tsc_pkg::*;

  // two half periods per bit, plus the setup half that opens the scan
  localparam int SCAN_HALVES     = 2 * NUM_FRAMES * FRAME_BITS + 1;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 64;
  localparam int CYCLE_LIMIT     = 100_000;
  localparam int ITEM_TARGET     = 550;

  typedef logic [NUM_FRAMES-1:0][FRAME_BITS-1:0] resp_set_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    results_owed;

  // tick timing as the block sees it, zero read as one
  int half_eff;
  int ival_eff;
  int burst_left;
  int ticks_sent;

  tsc_tick_if   tick_ch ();
  tsc_status_if status_ch ();

  touchscreen_adc_scan_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .status    (status_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tsc_scan_checker scan_check (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick_ch),
    .status         (status_ch),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Status side: stretches of always-ready, regular stalls and random stalls
  initial begin : status_stall
    int mode, span, period;
    status_ch.ready = 1'b0;
    forever begin
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(100, 600);
      period = $urandom_range(2, 5);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0:       status_ch.ready = 1'b1;
          1:       status_ch.ready = (c % period) != 0;
          default: status_ch.ready = $urandom_range(0, 2) != 0;
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // One tick; called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input logic miso_bit, input logic pen_bit);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        tick_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    tick_ch.valid = 1'b1;
    tick_ch.miso  = miso_bit;
    tick_ch.pen_n = pen_bit;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Register write once the block has returned every status item
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    tick_ch.valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_timing(input int half, input int ival);
    write_reg(REG_HALF_PERIOD, half);
    write_reg(REG_SAMPLE_INTERVAL, ival);
    half_eff = (half == 0) ? 1 : half;
    ival_eff = (ival == 0) ? 1 : ival;
  endtask

  // Response words giving chosen samples; the spare bits stay random
  function automatic resp_set_t shaped_set(input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] z1,
                                           input logic [COORD_W-1:0] z2,
                                           input logic [COORD_W-1:0] y);
    resp_set_t s;
    for (int f = 0; f < NUM_FRAMES; f++)
      s[f] = FRAME_BITS'($urandom);
    s[0][5:0]   = x[11:6];
    s[1][14:10] = x[4:0];
    s[1][5:0]   = z1[11:6];
    s[2][14:10] = z1[4:0];
    s[2][5:0]   = z2[11:6];
    s[3][14:10] = z2[4:0];
    s[3][5:0]   = y[11:6];
    s[4][14:10] = y[4:0];
    return s;
  endfunction

  // Mostly plain random words, with a share of saturating, clamped and silent scans
  function automatic resp_set_t random_set();
    resp_set_t s;
    case ($urandom_range(0, 9))
      6: s = shaped_set(12'hFC0 | 12'($urandom_range(0, 31)), 12'($urandom_range(1, 4)),
                        12'hFDF, 12'($urandom));
      7: s = shaped_set(12'($urandom_range(1, 4095)), 12'($urandom_range(2048, 4095)),
                        12'($urandom_range(0, 2047)), 12'($urandom));
      8: s = ($urandom_range(0, 1) != 0) ?
             shaped_set('0, 12'($urandom), 12'($urandom), 12'($urandom)) :
             shaped_set(12'($urandom_range(1, 4095)), '0, 12'($urandom), 12'($urandom));
      default: begin
        for (int f = 0; f < NUM_FRAMES; f++)
          s[f] = FRAME_BITS'($urandom);
      end
    endcase
    return s;
  endfunction

  // Ticks of one scan after its opening tick; miso carries the word bit on each
  // rising-clock tick and noise elsewhere, pen noise until the last clock fall
  task automatic do_scan(input resp_set_t set, input logic end_pen);
    int   span, last, g;
    logic bit_val;
    span = 2 * half_eff;
    last = SCAN_HALVES * half_eff;
    for (int t = 1; t <= last; t++) begin
      if (t % span == 0) begin
        g = t / span - 1;
        bit_val = set[g / FRAME_BITS][FRAME_BITS - 1 - g % FRAME_BITS];
      end else begin
        bit_val = 1'($urandom_range(0, 1));
      end
      send_tick(bit_val, (t == last) ? end_pen : 1'($urandom_range(0, 1)));
    end
  endtask

  // Interval wait; pen only matters on its last tick
  task automatic sit_out_interval(input logic last_pen);
    for (int t = 1; t <= ival_eff; t++)
      send_tick(1'($urandom_range(0, 1)), (t == ival_eff) ? last_pen : 1'($urandom_range(0, 1)));
  endtask

  // Touch session from idle: scans back to back, always left in idle
  task automatic run_session(input int scans, input resp_set_t first_set, input logic end_pen);
    resp_set_t set;
    logic      at_end;
    set = first_set;
    send_tick(1'($urandom_range(0, 1)), 1'b0);
    for (int i = 0; i < scans; i++) begin
      if (i > 0)
        set = random_set();
      at_end = (i < scans - 1) ? 1'b0 : end_pen;
      do_scan(set, at_end);
      if (!at_end)
        sit_out_interval(i == scans - 1);
    end
  endtask

  // Pen-up ticks while idle
  task automatic idle_noise(input int n);
    for (int i = 0; i < n; i++)
      send_tick(1'($urandom_range(0, 1)), 1'b1);
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_HALF_PERIOD;
    cfg_data      = '0;
    tick_ch.valid = 1'b0;
    tick_ch.miso  = 1'b0;
    tick_ch.pen_n = 1'b1;
    half_eff      = int'(HALF_RESET);
    ival_eff      = int'(IVAL_RESET);
    burst_left    = 0;
    ticks_sent    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // idle at reset timing
    idle_noise(4);

    // fastest timing: saturating pressure
    set_timing(1, 1);
    run_session(1, shaped_set(12'hFDF, 12'h001, 12'hFDF, 12'hFDF), 1'b1);

    // zero registers act as one; clamped difference, then a rescan with pen held
    set_timing(0, 0);
    run_session(2, shaped_set(12'h800, 12'hF00, 12'h100, 12'h000), 1'b0);

    // wide register values written, then pen-up ticks up to the item budget
    set_timing(255, 1048575);
    if (ticks_sent < ITEM_TARGET)
      idle_noise(ITEM_TARGET - ticks_sent);

    // drain
    tick_ch.valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
sv/tsc_pkg.sv
sv/tsc_tick_if.sv
sv/tsc_status_if.sv
sv/tsc_press.sv
sv/touchscreen_adc_scan_sequencer.sv
sv/tsc_checker.sv
test/tsc_scan_checker.sv
test/testbench.sv
